// ===== hw/rtl/sealed_block_header_parser_macros.svh =====
// Assertion macros used by the sealed block header parser RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SEALED_BLOCK_HEADER_PARSER_MACROS_SVH
`define SEALED_BLOCK_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SBHP_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sbhp: implication check failed");

// Next-cycle implication, disabled while in reset.
`define SBHP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sbhp: next-cycle check failed");

`endif

// ===== hw/rtl/sbhp_pkg.sv =====
package sbhp_pkg;

    // Header layout, byte offsets from the start of the block
    localparam int unsigned VERSION_START = 4;
    localparam int unsigned FLAGS_START   = 6;
    localparam int unsigned KEY_START     = 8;
    localparam int unsigned PLAIN_START   = 16;
    localparam int unsigned CIPHER_START  = 24;
    localparam int unsigned NONCE_START   = 32;
    localparam int unsigned HEADER_BYTES  = 56;

    // Authentication tag length in bytes
    localparam int unsigned TAG_BYTES = 16;

    // Byte position counter, saturating
    localparam int unsigned POS_W = 33;

    // Magic bytes "M2AE"
    localparam logic [7:0] MAGIC_WORD [4] = '{8'h4D, 8'h32, 8'h41, 8'h45};

    typedef enum logic [1:0] {
        KIND_NONCE   = 2'd0,
        KIND_CIPHER  = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LIMITS   = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_MAGIC    = 3'd3,
        ST_FLAGS    = 3'd4,
        ST_VERSION  = 3'd5,
        ST_SIZES    = 3'd6,
        ST_MISMATCH = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CFG_MAX_PLAIN   = 3'd0,
        CFG_MAX_CIPHER  = 3'd1,
        CFG_MAX_AAD     = 3'd2,
        CFG_MAX_WORKING = 3'd3,
        CFG_EXP_VERSION = 3'd4
    } cfg_index_t;

    typedef enum logic {
        PH_DATA    = 1'b0,
        PH_VERDICT = 1'b1
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [63:0] key_ident;
        logic [63:0] plain_length;
        logic [63:0] cipher_length;
        logic [2:0]  status;
        logic        final_res;
    } out_item_t;

    typedef struct packed {
        logic [31:0] max_plaintext_bytes;
        logic [31:0] max_ciphertext_bytes;
        logic [31:0] max_aad_bytes;
        logic [31:0] max_working_bytes;
        logic [15:0] expected_version;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        max_plaintext_bytes:  32'd65536,
        max_ciphertext_bytes: 32'd65552,
        max_aad_bytes:        32'd4096,
        max_working_bytes:    32'd262144,
        expected_version:     16'd1
    };

endpackage

// ===== hw/rtl/sbhp_parse.sv =====
`include "sealed_block_header_parser_macros.svh"

module sbhp_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hold_valid,
    input  sbhp_pkg::in_item_t  hold,
    input  sbhp_pkg::cfg_t      cfg,
    input  logic                out_free,
    output logic                consume,
    output logic                push,
    output sbhp_pkg::out_item_t push_data
);
    import sbhp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               magic_bad_reg, magic_bad_next;
    logic               flags_bad_reg, flags_bad_next;
    logic [15:0]        version_reg, version_next;
    logic [63:0]        key_reg, key_next;
    logic [63:0]        plain_reg, plain_next;
    logic [63:0]        cipher_reg, cipher_next;

    logic               forward;
    logic [POS_W:0]     total;
    logic [POS_W:0]     payload_len;
    logic               limits_bad;
    logic               sizes_ok;
    logic [64:0]        work_sum;
    status_t            verdict;

    // Byte classification by position
    assign forward = pos_reg >= POS_W'(NONCE_START);

    // Verdict checks, evaluated from the block state on the final byte
    assign total       = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign payload_len = total - (POS_W+1)'(HEADER_BYTES);
    assign work_sum    = {1'b0, cipher_reg} + {1'b0, plain_reg};

    assign limits_bad = (cfg.max_plaintext_bytes == '0)
                     || (cfg.max_ciphertext_bytes < 32'(TAG_BYTES))
                     || (cfg.max_aad_bytes == '0)
                     || (cfg.max_working_bytes == '0);

    assign sizes_ok = (cipher_reg <= {32'd0, cfg.max_ciphertext_bytes})
                   && (cipher_reg >= 64'(TAG_BYTES))
                   && (plain_reg <= {32'd0, cfg.max_plaintext_bytes})
                   && ((cipher_reg - 64'(TAG_BYTES)) == plain_reg)
                   && (work_sum <= {33'd0, cfg.max_working_bytes});

    always_comb
    begin
        priority if (limits_bad)
            verdict = ST_LIMITS;
        else if (total < (POS_W+1)'(HEADER_BYTES))
            verdict = ST_TRUNC;
        else if (magic_bad_reg)
            verdict = ST_MAGIC;
        else if (flags_bad_reg)
            verdict = ST_FLAGS;
        else if (version_reg != cfg.expected_version)
            verdict = ST_VERSION;
        else if (!sizes_ok)
            verdict = ST_SIZES;
        else if (64'(payload_len) != cipher_reg)
            verdict = ST_MISMATCH;
        else
            verdict = ST_OK;
    end

    // Phase sequencing, header field capture and result generation
    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        magic_bad_next = magic_bad_reg;
        flags_bad_next = flags_bad_reg;
        version_next   = version_reg;
        key_next       = key_reg;
        plain_next     = plain_reg;
        cipher_next    = cipher_reg;
        consume        = 1'b0;
        push           = 1'b0;
        push_data      = '0;

        unique case (phase_reg)
            PH_DATA:
            begin
                push_data.kind       = (pos_reg >= POS_W'(HEADER_BYTES)) ? KIND_CIPHER
                                                                       : KIND_NONCE;
                push_data.byte_value = hold.data_byte;
                if (hold_valid && (!forward || out_free))
                begin
                    push = forward;
                    // Capture header fields
                    priority if (pos_reg < POS_W'(VERSION_START))
                    begin
                        if (hold.data_byte != MAGIC_WORD[pos_reg[1:0]])
                            magic_bad_next = 1'b1;
                    end
                    else if (pos_reg < POS_W'(FLAGS_START))
                        version_next[{pos_reg[0], 3'b000} +: 8] = hold.data_byte;
                    else if (pos_reg < POS_W'(KEY_START))
                    begin
                        if (hold.data_byte != '0)
                            flags_bad_next = 1'b1;
                    end
                    else if (pos_reg < POS_W'(PLAIN_START))
                        key_next[{pos_reg[2:0], 3'b000} +: 8] = hold.data_byte;
                    else if (pos_reg < POS_W'(CIPHER_START))
                        plain_next[{pos_reg[2:0], 3'b000} +: 8] = hold.data_byte;
                    else if (pos_reg < POS_W'(NONCE_START))
                        cipher_next[{pos_reg[2:0], 3'b000} +: 8] = hold.data_byte;
                    else
                    begin
                    end

                    // Hold the final byte for its verdict, else advance
                    if (hold.end_of_block)
                        phase_next = PH_VERDICT;
                    else
                    begin
                        consume = 1'b1;
                        if (pos_reg != '1)
                            pos_next = pos_reg + POS_W'(1);
                    end
                end
            end
            PH_VERDICT:
            begin
                push_data.kind          = KIND_VERDICT;
                push_data.key_ident     = key_reg;
                push_data.plain_length  = plain_reg;
                push_data.cipher_length = cipher_reg;
                push_data.status        = verdict;
                push_data.final_res     = 1'b1;
                if (out_free)
                begin
                    push           = 1'b1;
                    consume        = 1'b1;
                    phase_next     = PH_DATA;
                    pos_next       = '0;
                    magic_bad_next = 1'b0;
                    flags_bad_next = 1'b0;
                    version_next   = '0;
                    key_next       = '0;
                    plain_next     = '0;
                    cipher_next    = '0;
                end
            end
            default:
            begin
                phase_next = PH_DATA;
            end
        endcase
    end

    // Block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DATA;
            pos_reg       <= '0;
            magic_bad_reg <= 1'b0;
            flags_bad_reg <= 1'b0;
            version_reg   <= '0;
            key_reg       <= '0;
            plain_reg     <= '0;
            cipher_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            magic_bad_reg <= magic_bad_next;
            flags_bad_reg <= flags_bad_next;
            version_reg   <= version_next;
            key_reg       <= key_next;
            plain_reg     <= plain_next;
            cipher_reg    <= cipher_next;
        end
    end

    `SBHP_ASSERT_IMPLY(a_verdict_has_item, phase_reg == PH_VERDICT, hold_valid)
    `SBHP_ASSERT_IMPLY(a_push_has_room, push, out_free)
    `SBHP_ASSERT_IMPLY(a_final_not_dropped, consume && phase_reg == PH_DATA, !hold.end_of_block)
    `SBHP_ASSERT_NEXT(a_verdict_clears, phase_reg == PH_VERDICT && out_free, pos_reg == '0 && phase_reg == PH_DATA)

endmodule

// ===== hw/rtl/sealed_block_header_parser.sv =====
// A forwarded byte passes through the input register and then the result register;
// the verdict is pushed into the result register from the verdict phase.
// Throughput: one byte per cycle unless stalled; a block's final byte holds the input
// register till its verdict is pushed; a stalled result stalls nonce and payload bytes.
// Reset: asynchronous, active low; clears block state and both registers' valid
// flags and loads the configuration defaults. No clearing pass is needed.
module sealed_block_header_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  sbhp_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output sbhp_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import sbhp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       hold_valid_reg, hold_valid_next;
    in_item_t   hold_reg;
    logic       result_valid_reg, result_valid_next;
    out_item_t  result_reg;

    logic       consume;
    logic       push;
    out_item_t  push_data;
    logic       out_free;
    logic       item_take;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_PLAIN:   cfg_next.max_plaintext_bytes  = cfg_data;
                CFG_MAX_CIPHER:  cfg_next.max_ciphertext_bytes = cfg_data;
                CFG_MAX_AAD:     cfg_next.max_aad_bytes        = cfg_data;
                CFG_MAX_WORKING: cfg_next.max_working_bytes    = cfg_data;
                CFG_EXP_VERSION: cfg_next.expected_version     = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Input register: stall only while the held byte cannot move on
    assign item_stall = hold_valid_reg && !consume;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        if (item_take)
            hold_valid_next = 1'b1;
        else if (consume)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            hold_reg <= item;
    end

    sbhp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid_reg),
        .hold       (hold_reg),
        .cfg        (cfg_reg),
        .out_free   (out_free),
        .consume    (consume),
        .push       (push),
        .push_data  (push_data)
    );

    // Result register: free when empty or when its transfer completes now
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        if (push)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            result_reg <= push_data;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
